// ----- rtl/stb_pkg.sv -----
// Shared constants and command codes for the software timer bank.
`timescale 1ns / 1ps

package stb_pkg;

   // Bank geometry
   localparam int NUM_TIMERS = 64;
   localparam int TICK_WIDTH = 32;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // Field widths of one request and one response word
   localparam int CMD_W    = 4;
   localparam int INDEX_W  = 8;
   localparam int LIMIT_W  = 32;
   localparam int NOW_W    = 32;
   localparam int RESULT_W = 16;

   // Packed word widths, rounded up to whole bytes
   localparam int REQ_BITS   = CMD_W + INDEX_W + LIMIT_W + NOW_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   // Answer for an index beyond the bank
   localparam logic [RESULT_W-1:0] BAD_INDEX = 16'hFFFF;

   // Request commands; codes above CMD_GET_START clear the entry
   typedef enum logic [CMD_W-1:0] {
      CMD_START         = 4'd0,
      CMD_RESTART       = 4'd1,
      CMD_GET_TICK      = 4'd2,
      CMD_CHECK         = 4'd3,
      CMD_CHECK_RESTART = 4'd4,
      CMD_CHECK_STOP    = 4'd5,
      CMD_STOP          = 4'd6,
      CMD_GET_START     = 4'd7
   } cmd_type;

endpackage

// ----- rtl/software_timer_bank_top.sv -----
// Software timer bank: start-tick store with command decode and expiry check.
//
//   channel | direction | tdata fields (low bit up)                         | tuser/tlast
//   req_    | in        | command[3:0] timer_index[11:4] timeout_ticks[43:12]
//           |           | current_tick[75:44], zero fill to 80 bits         | none
//   rsp_    | out       | result_value[15:0]                                | none
//
// One request is taken per cycle. The start-tick memory is read when a word is
// accepted and written when the word leaves the execute stage; a word written
// as a request is accepted is bypassed into that request. A request passes
// through the execute stage and then the response register. Reset clears the
// per-entry valid bits at once, so every timer reads as stopped right away. A
// stalled response holds the execute stage and then the input side.
`timescale 1ns / 1ps

module software_timer_bank_top (
   input  logic                             clock,
   input  logic                             reset,
   // command, timer_index, timeout_ticks, current_tick, zero fill
   input  logic [stb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // result_value
   output logic [stb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import stb_pkg::*;

   localparam int CMD_LO   = 0;
   localparam int INDEX_LO = CMD_LO + CMD_W;
   localparam int LIMIT_LO = INDEX_LO + INDEX_W;
   localparam int NOW_LO   = LIMIT_LO + LIMIT_W;

   // Unpack the request word
   logic [CMD_W-1:0]      req_command;
   logic [INDEX_W-1:0]    req_index;
   logic [LIMIT_W-1:0]    req_limit;
   logic [TICK_WIDTH-1:0] req_now;

   assign req_command = req_tdata[CMD_LO +: CMD_W];
   assign req_index   = req_tdata[INDEX_LO +: INDEX_W];
   assign req_limit   = req_tdata[LIMIT_LO +: LIMIT_W];
   assign req_now     = req_tdata[NOW_LO +: TICK_WIDTH];

   // Start-tick memory and per-entry valid bits
   logic [TICK_WIDTH-1:0] tick_mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] entry_valid_ff;

   // Execute stage
   logic                  exe_valid_ff;
   logic [CMD_W-1:0]      exe_command_ff;
   logic [INDEX_W-1:0]    exe_index_ff;
   logic [LIMIT_W-1:0]    exe_limit_ff;
   logic [TICK_WIDTH-1:0] exe_now_ff;
   logic [TICK_WIDTH-1:0] exe_rd_data_ff;
   logic                  exe_rd_valid_ff;
   logic                  exe_byp_ff;
   logic [TICK_WIDTH-1:0] exe_byp_data_ff;

   // Response register
   logic                  rsp_valid_ff;
   logic [RESULT_W-1:0]   rsp_value_ff;

   logic                  req_fire;
   logic                  exe_fire;
   logic                  wr_en;
   logic [TICK_WIDTH-1:0] wr_data;
   logic [RESULT_W-1:0]   result;
   logic                  byp_in;
   logic [TICK_WIDTH-1:0] cur;
   logic                  running;
   logic [TICK_WIDTH-1:0] elapsed;
   logic                  expired;
   logic                  bad_index;

   // Handshakes: execute advances when the response slot is free or drains
   assign exe_fire   = exe_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !exe_valid_ff || exe_fire;
   assign req_fire   = req_tvalid && req_tready;

   // Forward the write of this cycle into the word read at the same edge
   assign byp_in = exe_fire && wr_en && (exe_index_ff == req_index);

   // Entry value seen by the execute stage
   assign cur       = exe_byp_ff ? exe_byp_data_ff
                    : (exe_rd_valid_ff ? exe_rd_data_ff : '0);
   assign running   = (cur != '0);
   assign elapsed   = exe_now_ff - cur;
   assign expired   = (LIMIT_W'(elapsed) > exe_limit_ff);
   assign bad_index = ({1'b0, exe_index_ff} >= (INDEX_W + 1)'(NUM_TIMERS));

   // Decode the command into a result and an entry update
   always_comb begin
      wr_en   = 1'b0;
      wr_data = '0;
      result  = '0;
      if (bad_index) begin
         result = BAD_INDEX;
      end else begin
         unique case (exe_command_ff)
            CMD_START: begin
               if (!running) begin
                  wr_en   = 1'b1;
                  wr_data = exe_now_ff;
               end else begin
                  result = cur[RESULT_W-1:0];
               end
            end
            CMD_RESTART: begin
               wr_en   = 1'b1;
               wr_data = exe_now_ff;
               result  = exe_now_ff[RESULT_W-1:0];
            end
            CMD_GET_TICK: begin
               result = exe_now_ff[RESULT_W-1:0];
            end
            CMD_CHECK: begin
               result = RESULT_W'(running && expired);
            end
            CMD_CHECK_RESTART: begin
               if (running && expired) begin
                  wr_en   = 1'b1;
                  wr_data = exe_now_ff;
                  result  = RESULT_W'(1);
               end
            end
            CMD_CHECK_STOP: begin
               if (running && expired) begin
                  wr_en  = 1'b1;
                  result = RESULT_W'(1);
               end
            end
            CMD_STOP: begin
               if (running) begin
                  wr_en  = 1'b1;
                  result = RESULT_W'(expired);
               end
            end
            CMD_GET_START: begin
               result = cur[RESULT_W-1:0];
            end
            default: begin
               wr_en  = 1'b1;
               result = RESULT_W'(1);
            end
         endcase
      end
   end

   // Memory: read on accept, write when execute advances
   always_ff @(posedge clock) begin
      if (exe_fire && wr_en) begin
         tick_mem[exe_index_ff[IDX_W-1:0]] <= wr_data;
      end
      if (req_fire) begin
         exe_rd_data_ff <= tick_mem[req_index[IDX_W-1:0]];
      end
   end

   // Control state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         if (req_fire) begin
            exe_valid_ff <= 1'b1;
         end else if (exe_fire) begin
            exe_valid_ff <= 1'b0;
         end
         if (exe_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (exe_fire && wr_en) begin
            entry_valid_ff[exe_index_ff[IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   // Payload of the execute stage and the response
   always_ff @(posedge clock) begin
      if (req_fire) begin
         exe_command_ff  <= req_command;
         exe_index_ff    <= req_index;
         exe_limit_ff    <= req_limit;
         exe_now_ff      <= req_now;
         exe_rd_valid_ff <= entry_valid_ff[req_index[IDX_W-1:0]];
         exe_byp_ff      <= byp_in;
         exe_byp_data_ff <= wr_data;
      end
      if (exe_fire) begin
         rsp_value_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);

endmodule
